@@ rtl/psg_register_write_translator_macros.svh @@
// assertion macros for the psg register write translator
// used by the top level only; expects signals clk and rst in scope
`ifndef PSG_REGISTER_WRITE_TRANSLATOR_MACROS_SVH
`define PSG_REGISTER_WRITE_TRANSLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/psgrwt_pkg.sv @@
// shared types, register numbers and lookup tables of the write translator
// no dependencies
package psgrwt_pkg;

  // register numbers of the three-channel chip
  localparam logic [3:0] REG_NOISE_PITCH = 4'd6;
  localparam logic [3:0] REG_MIXER       = 4'd7;

  // one register write
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] value;
  } wr_t;

  // all writes caused by one input word, wr[0] goes out first
  typedef struct packed {
    logic [1:0]      count;
    wr_t [2:0]       wr;
  } job_t;

  // attenuation to volume mapping
  function automatic logic [7:0] vol_map(input logic [3:0] att);
    logic [7:0] v;
    case (att)
      4'd0:    v = 8'd15;
      4'd1:    v = 8'd14;
      4'd2:    v = 8'd14;
      4'd3:    v = 8'd13;
      4'd4:    v = 8'd12;
      4'd5:    v = 8'd12;
      4'd6:    v = 8'd11;
      4'd7:    v = 8'd10;
      4'd8:    v = 8'd10;
      4'd9:    v = 8'd9;
      4'd10:   v = 8'd8;
      4'd11:   v = 8'd8;
      4'd12:   v = 8'd7;
      4'd13:   v = 8'd6;
      4'd14:   v = 8'd6;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // noise pitch from the rate code, code 3 follows tone 2
  function automatic logic [7:0] noise_pitch(input logic [1:0] code, input logic [4:0] tone2);
    logic [7:0] p;
    case (code)
      2'd0:    p = 8'd7;
      2'd1:    p = 8'd15;
      2'd2:    p = 8'd31;
      default: p = {3'b000, tone2};
    endcase
    return p;
  endfunction

endpackage

@@ rtl/psg_register_write_translator.sv @@
// top level of the psg register write translator
// depends on psgrwt_pkg, psgrwt_front, psgrwt_queue, psgrwt_back and the macro header
//
// Each byte written to the four-channel chip is accepted while the job queue is not
// full and turned into zero to three register writes (address, value, last) for the
// three-channel chip. The front end classifies the byte and updates its copy of the
// chip state in the accept cycle, a QUEUE_DEPTH-entry job queue holds the write
// lists, and the back end sends one write per cycle from its output register. The
// first write of a byte passes the queue entry, the job register and the output
// register before it is offered. The output channel sets the sustained rate: one
// write per cycle while m_axis_tready is high, so a byte holds the output for as
// many writes as it causes; a byte with no write queues no job. shared_channel is
// written on the cfg channel, which is always ready; a value of 3 acts as 2.
module psg_register_write_translator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // reg_addr[3:0], reg_value[11:4], zero pad
  output logic        m_axis_tlast,    // last_write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data         // shared_channel
);
  import psgrwt_pkg::*;
`include "psg_register_write_translator_macros.svh"

  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;

  // byte intake and classification
  psgrwt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  // job queue
  psgrwt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  // write sequencer
  psgrwt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head_job      (head_job),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // checks
  `PSG_ASSERT_IMP(a_push_on_accept, push, s_axis_tvalid && s_axis_tready && !q_full, "push without accepted byte")
  `PSG_ASSERT_IMP(a_push_nonempty, push, push_job.count != 2'd0, "empty write list queued")
  `PSG_ASSERT_IMP(a_pop_valid, pop, q_valid, "pop from empty queue")

endmodule

@@ rtl/psgrwt_front.sv @@
// front end: accepts written bytes, keeps chip state, builds the write list
// depends on psgrwt_pkg
module psgrwt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // in_byte
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_data,
  input  logic                q_full,
  output logic                push,
  output psgrwt_pkg::job_t    job
);
  import psgrwt_pkg::*;

  logic [9:0] tone_period [3];
  logic [3:0] attenuation [4];
  logic [1:0] latched_channel;
  logic       latched_is_volume;
  logic [1:0] shared_channel;

  logic [9:0] period_next [3];
  logic [3:0] att_next [4];
  logic       accept;
  logic [7:0] b;
  logic [1:0] ch;
  logic [1:0] pch;
  logic [9:0] pv;
  logic       tone_on;
  logic       noise_on;
  logic [2:0] chan_bit;
  logic [2:0] tone_mask;
  logic [2:0] noise_mask;
  logic [3:0] shared_att;
  wr_t        mix_wr;
  wr_t        svol_wr;

  assign b             = s_axis_tdata;
  assign ch            = b[6:5];
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // updated attenuation and period state
  always_comb begin
    for (int i = 0; i < 4; i++) att_next[i] = attenuation[i];
    for (int i = 0; i < 3; i++) period_next[i] = tone_period[i];
    pch = b[7] ? ch : latched_channel;
    if (b[7]) begin
      if (b[4]) begin
        att_next[ch] = b[3:0];
      end else if (ch != 2'd3) begin
        period_next[ch] = {tone_period[ch][9:4], b[3:0]};
      end
    end else if (!latched_is_volume && latched_channel != 2'd3) begin
      period_next[latched_channel] = {b[5:0], tone_period[latched_channel][3:0]};
    end
  end

  // period of the addressed tone channel
  always_comb begin
    case (pch)
      2'd0:    pv = period_next[0];
      2'd1:    pv = period_next[1];
      default: pv = period_next[2];
    endcase
  end

  // mixer and volume of the shared channel, noise wins
  always_comb begin
    tone_on    = att_next[shared_channel] != 4'hf;
    noise_on   = att_next[3] != 4'hf;
    chan_bit   = 3'b001 << shared_channel;
    shared_att = noise_on ? att_next[3] : att_next[shared_channel];
    tone_mask  = (tone_on && !noise_on) ? 3'b000 : chan_bit;
    noise_mask = noise_on ? ~chan_bit : 3'b111;
    mix_wr.addr    = REG_MIXER;
    mix_wr.value   = {2'b00, noise_mask, tone_mask};
    svol_wr.addr   = {2'b10, shared_channel};
    svol_wr.value  = vol_map(shared_att);
  end

  // write list for this byte
  always_comb begin
    job = '0;
    if (b[7]) begin
      if (b[4]) begin
        if (ch == shared_channel || ch == 2'd3) begin
          job.count = 2'd2;
          job.wr[0] = mix_wr;
          job.wr[1] = svol_wr;
        end else begin
          job.count       = 2'd1;
          job.wr[0].addr  = {2'b10, ch};
          job.wr[0].value = vol_map(b[3:0]);
        end
      end else if (ch == 2'd3) begin
        job.count       = 2'd3;
        job.wr[0]       = mix_wr;
        job.wr[1]       = svol_wr;
        job.wr[2].addr  = REG_NOISE_PITCH;
        job.wr[2].value = noise_pitch(b[1:0], tone_period[2][4:0]);
      end else begin
        job.count       = 2'd2;
        job.wr[0].addr  = {1'b0, pch, 1'b0};
        job.wr[0].value = pv[7:0];
        job.wr[1].addr  = {1'b0, pch, 1'b1};
        job.wr[1].value = {6'b000000, pv[9:8]};
      end
    end else if (!latched_is_volume && latched_channel != 2'd3) begin
      job.count       = 2'd2;
      job.wr[0].addr  = {1'b0, pch, 1'b0};
      job.wr[0].value = pv[7:0];
      job.wr[1].addr  = {1'b0, pch, 1'b1};
      job.wr[1].value = {6'b000000, pv[9:8]};
    end
  end

  assign push = accept && (job.count != 2'd0);

  // chip state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) tone_period[i] <= '0;
      for (int i = 0; i < 4; i++) attenuation[i] <= 4'hf;
      latched_channel   <= '0;
      latched_is_volume <= 1'b0;
      shared_channel    <= 2'd2;
    end else begin
      if (cfg_valid) begin
        shared_channel <= (cfg_data == 2'd3) ? 2'd2 : cfg_data;
      end
      if (accept) begin
        for (int i = 0; i < 3; i++) tone_period[i] <= period_next[i];
        for (int i = 0; i < 4; i++) attenuation[i] <= att_next[i];
        if (b[7]) begin
          latched_channel   <= ch;
          latched_is_volume <= b[4];
        end
      end
    end
  end

endmodule

@@ rtl/psgrwt_queue.sv @@
// short job queue between the front end and the write sequencer
// depends on psgrwt_pkg
module psgrwt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  psgrwt_pkg::job_t    push_job,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output psgrwt_pkg::job_t    head_job
);
  import psgrwt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign q_valid  = count != '0;
  assign head_job = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/psgrwt_back.sv @@
// back end: sends the writes of each job one word at a time
// depends on psgrwt_pkg
module psgrwt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  psgrwt_pkg::job_t    head_job,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // reg_addr[3:0], reg_value[11:4], zero pad
  output logic                m_axis_tlast    // last_write
);
  import psgrwt_pkg::*;

  job_t       cur_job;
  logic       job_valid;
  logic [1:0] idx;
  wr_t        out_wr;
  logic       out_last;
  logic       advance;
  logic       is_last;

  assign advance = job_valid && (!m_axis_tvalid || m_axis_tready);
  assign is_last = idx == (cur_job.count - 2'd1);
  assign pop     = q_valid && (!job_valid || (advance && is_last));

  assign m_axis_tdata = {4'b0000, out_wr.value, out_wr.addr};
  assign m_axis_tlast = out_last;

  // output word register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_wr   <= cur_job.wr[idx];
      out_last <= is_last;
    end
  end

  // job register and write index
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid     <= 1'b0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (pop) begin
        job_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (advance) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
        if (is_last) job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_job <= head_job;
  end

endmodule
